// ----- design/deq_pkg.sv -----
// Shared types and constants for the double-ended queue.
`default_nettype none

package deq_pkg;

  // Default store geometry
  localparam int unsigned DEQ_DEPTH       = 16;
  localparam int unsigned DEQ_VALUE_WIDTH = 32;

  // Widths of the command, value and status ports
  localparam int unsigned CMD_WIDTH    = 3;
  localparam int unsigned PORT_WIDTH   = 32;
  localparam int unsigned STATUS_WIDTH = 2;

  // Depth of the command queue between front and back
  localparam int unsigned CMDQ_DEPTH = 2;

  // Operation codes, equal to the command codes on the port
  typedef enum logic [CMD_WIDTH-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_DUMP       = 3'd4
  } op_e;

  // Result status codes
  typedef enum logic [STATUS_WIDTH-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Back-end sequencer states
  typedef enum logic {
    BK_RUN,
    BK_DUMP
  } back_state_e;

endpackage

`default_nettype wire

// ----- design/deq_front.sv -----
// Command front end: takes transactions, drops unused codes, feeds the command queue.
`default_nettype none

module deq_front import deq_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = DEQ_VALUE_WIDTH
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  output      logic                   busy_o,
  input  wire logic [CMD_WIDTH-1:0]   command_i,
  input  wire logic [PORT_WIDTH-1:0]  push_value_i,
  // toward the command queue
  output      logic                   q_push_o,
  output      op_e                    q_op_o,
  output      logic [VALUE_WIDTH-1:0] q_value_o,
  input  wire logic                   q_full_i
);

  logic                   hold_valid_q, hold_valid_d;
  op_e                    hold_op_q, hold_op_d;
  logic [VALUE_WIDTH-1:0] hold_value_q, hold_value_d;
  logic                   accept;
  logic                   code_ok;
  op_e                    dec_op;
  logic [VALUE_WIDTH-1:0] in_value;

  // Fit the port value to the store width (zero fill when wider)
  if (VALUE_WIDTH <= PORT_WIDTH) begin : g_narrow
    assign in_value = push_value_i[VALUE_WIDTH-1:0];
  end else begin : g_wide
    assign in_value = {{(VALUE_WIDTH-PORT_WIDTH){1'b0}}, push_value_i};
  end

  // Command decode; codes past dump are dropped
  always_comb begin
    code_ok = 1'b1;
    dec_op  = OP_PUSH_FRONT;
    unique case (command_i)
      OP_PUSH_FRONT: dec_op = OP_PUSH_FRONT;
      OP_PUSH_BACK:  dec_op = OP_PUSH_BACK;
      OP_POP_FRONT:  dec_op = OP_POP_FRONT;
      OP_POP_BACK:   dec_op = OP_POP_BACK;
      OP_DUMP:       dec_op = OP_DUMP;
      default:       code_ok = 1'b0;
    endcase
  end

  assign busy_o   = hold_valid_q & q_full_i;
  assign accept   = start_i & ~busy_o;
  assign q_push_o = hold_valid_q & ~q_full_i;
  assign q_op_o   = hold_op_q;
  assign q_value_o = hold_value_q;

  // Holding stage update
  always_comb begin
    hold_valid_d = hold_valid_q & ~q_push_o;
    hold_op_d    = hold_op_q;
    hold_value_d = hold_value_q;
    if (accept && code_ok) begin
      hold_valid_d = 1'b1;
      hold_op_d    = dec_op;
      hold_value_d = in_value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_op_q    <= hold_op_d;
    hold_value_q <= hold_value_d;
  end

endmodule

`default_nettype wire

// ----- design/deq_cmd_queue.sv -----
// Short command queue between the front end and the back end.
`default_nettype none

module deq_cmd_queue import deq_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = DEQ_VALUE_WIDTH
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push_i,
  input  wire op_e                    op_i,
  input  wire logic [VALUE_WIDTH-1:0] value_i,
  output      logic                   full_o,
  input  wire logic                   pop_i,
  output      logic                   valid_o,
  output      op_e                    op_o,
  output      logic [VALUE_WIDTH-1:0] value_o
);

  localparam int unsigned PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(CMDQ_DEPTH + 1);

  op_e                    op_q    [CMDQ_DEPTH];
  logic [VALUE_WIDTH-1:0] value_q [CMDQ_DEPTH];
  logic [PTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic                   do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(CMDQ_DEPTH));
  assign valid_o = (count_q != '0);
  assign op_o    = op_q[rd_ptr_q];
  assign value_o = value_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + CNT_W'(1);
      2'b01:   count_d = count_q - CNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      op_q[wr_ptr_q]    <= op_i;
      value_q[wr_ptr_q] <= value_i;
    end
  end

endmodule

`default_nettype wire

// ----- design/deq_back.sv -----
// Back end: ring store, end pointers and result generation.
`default_nettype none

module deq_back import deq_pkg::*; #(
  parameter int unsigned DEPTH       = DEQ_DEPTH,
  parameter int unsigned VALUE_WIDTH = DEQ_VALUE_WIDTH
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  // from the command queue
  input  wire logic                    q_valid_i,
  input  wire op_e                     q_op_i,
  input  wire logic [VALUE_WIDTH-1:0]  q_value_i,
  output      logic                    q_pop_o,
  // result transaction
  output      logic                    out_valid_o,
  output      logic [PORT_WIDTH-1:0]   out_value_o,
  output      logic [STATUS_WIDTH-1:0] status_o,
  output      logic                    last_of_run_o
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W:0] DEPTH_L = (IDX_W+1)'(DEPTH);

  // Ring store with registered read
  logic [VALUE_WIDTH-1:0] mem_q [DEPTH];
  logic [VALUE_WIDTH-1:0] rd_data_q;
  logic [IDX_W-1:0]       rd_addr;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;

  back_state_e      state_q, state_d;
  logic [IDX_W-1:0] front_q, front_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] walk_idx_q, walk_idx_d;

  logic    res_valid_q, res_valid_d;
  status_e res_status_q, res_status_d;
  logic    res_last_q, res_last_d;
  logic    res_sel_q, res_sel_d;

  logic             take;
  logic             is_full, is_empty;
  logic [CNT_W-1:0] count_m1;
  logic             walk_last;
  logic [IDX_W-1:0] front_dec;
  logic [IDX_W-1:0] slot_back, slot_tail, slot_walk, slot_next;

  // Slot of front plus an offset below DEPTH, wrapped by one compare and subtract
  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                input logic [IDX_W-1:0] off);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DEPTH_L) begin
      sum = sum - DEPTH_L;
    end
    return sum[IDX_W-1:0];
  endfunction

  assign is_full   = (count_q == CNT_W'(DEPTH));
  assign is_empty  = (count_q == '0);
  assign count_m1  = count_q - CNT_W'(1);
  assign walk_last = ((CNT_W'(walk_idx_q) + CNT_W'(1)) == count_q);
  assign front_dec = (front_q == '0) ? IDX_W'(DEPTH - 1) : front_q - IDX_W'(1);
  assign slot_back = wrap_add(front_q, count_q[IDX_W-1:0]);
  assign slot_tail = wrap_add(front_q, count_m1[IDX_W-1:0]);
  assign slot_walk = wrap_add(front_q, walk_idx_q);
  assign slot_next = wrap_add(front_q, IDX_W'(1));

  assign take    = q_valid_i & (state_q == BK_RUN);
  assign q_pop_o = take;

  // Next state: a dump of more than one entry walks the store
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_RUN: begin
        if (take && (q_op_i == OP_DUMP) && (count_q > CNT_W'(1))) begin
          state_d = BK_DUMP;
        end
      end
      BK_DUMP: begin
        if (walk_last) begin
          state_d = BK_RUN;
        end
      end
      default: state_d = BK_RUN;
    endcase
  end

  // Operation datapath and result staging
  always_comb begin
    front_d      = front_q;
    count_d      = count_q;
    walk_idx_d   = walk_idx_q;
    wr_en        = 1'b0;
    wr_addr      = slot_back;
    rd_addr      = front_q;
    res_valid_d  = 1'b0;
    res_status_d = ST_OK;
    res_last_d   = 1'b1;
    res_sel_d    = 1'b0;
    unique case (state_q)
      BK_RUN: begin
        if (take) begin
          res_valid_d = 1'b1;
          unique case (q_op_i)
            OP_PUSH_FRONT: begin
              if (is_full) begin
                res_status_d = ST_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = front_dec;
                front_d = front_dec;
                count_d = count_q + CNT_W'(1);
              end
            end
            OP_PUSH_BACK: begin
              if (is_full) begin
                res_status_d = ST_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = slot_back;
                count_d = count_q + CNT_W'(1);
              end
            end
            OP_POP_FRONT: begin
              if (is_empty) begin
                res_status_d = ST_EMPTY;
              end else begin
                rd_addr   = front_q;
                res_sel_d = 1'b1;
                front_d   = slot_next;
                count_d   = count_m1;
              end
            end
            OP_POP_BACK: begin
              if (is_empty) begin
                res_status_d = ST_EMPTY;
              end else begin
                rd_addr   = slot_tail;
                res_sel_d = 1'b1;
                count_d   = count_m1;
              end
            end
            OP_DUMP: begin
              if (is_empty) begin
                res_status_d = ST_EMPTY;
              end else begin
                rd_addr    = front_q;
                res_sel_d  = 1'b1;
                res_last_d = (count_q == CNT_W'(1));
                walk_idx_d = IDX_W'(1);
              end
            end
            default: res_valid_d = 1'b0;
          endcase
        end
      end
      BK_DUMP: begin
        rd_addr     = slot_walk;
        res_valid_d = 1'b1;
        res_sel_d   = 1'b1;
        res_last_d  = walk_last;
        walk_idx_d  = walk_idx_q + IDX_W'(1);
      end
      default: res_valid_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_RUN;
      front_q     <= '0;
      count_q     <= '0;
      walk_idx_q  <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      count_q     <= count_d;
      walk_idx_q  <= walk_idx_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_last_q   <= res_last_d;
    res_sel_q    <= res_sel_d;
  end

  // Store write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= q_value_i;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  // Result ports; value is zero unless an entry was read
  logic [PORT_WIDTH-1:0] rd_port;
  if (VALUE_WIDTH >= PORT_WIDTH) begin : g_out_wide
    assign rd_port = rd_data_q[PORT_WIDTH-1:0];
  end else begin : g_out_narrow
    assign rd_port = {{(PORT_WIDTH-VALUE_WIDTH){1'b0}}, rd_data_q};
  end

  assign out_valid_o   = res_valid_q;
  assign out_value_o   = res_sel_q ? rd_port : '0;
  assign status_o      = res_status_q;
  assign last_of_run_o = res_last_q;

endmodule

`default_nettype wire

// ----- design/double_ended_queue.sv -----
// Double-ended queue top level: ring store of DEPTH values with push/pop at both ends and dump.
//
// A command transaction is taken at a clock edge where start_i is high and busy_o is low;
// codes five to seven are taken and dropped without a result. Push and pop give one result
// each and sustain one command per clock while no dump is running; the result appears on the
// out_* ports, marked by out_valid_o for one cycle, after the command has passed the holding
// stage, the command queue and the store access with its registered read. A dump
// gives one result per stored value, front to back, one per clock from the single read port
// of the ring store, with last_of_run_o on the final one; commands taken meanwhile wait in
// the two-entry command queue and busy_o rises once it and the holding stage are full.
// Results cannot be held off by the receiver.
`default_nettype none

module double_ended_queue import deq_pkg::*; #(
  parameter int unsigned DEPTH       = DEQ_DEPTH,
  parameter int unsigned VALUE_WIDTH = DEQ_VALUE_WIDTH
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  output      logic                    busy_o,
  input  wire logic [CMD_WIDTH-1:0]    command_i,
  input  wire logic signed [PORT_WIDTH-1:0] push_value_i,
  output      logic                    out_valid_o,
  output      logic signed [PORT_WIDTH-1:0] out_value_o,
  output      logic [STATUS_WIDTH-1:0] status_o,
  output      logic                    last_of_run_o
);

  logic                   fq_push;
  op_e                    fq_op;
  logic [VALUE_WIDTH-1:0] fq_value;
  logic                   fq_full;
  logic                   qb_valid;
  op_e                    qb_op;
  logic [VALUE_WIDTH-1:0] qb_value;
  logic                   qb_pop;
  logic [PORT_WIDTH-1:0]  out_value;

  deq_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .command_i    (command_i),
    .push_value_i (push_value_i),
    .q_push_o     (fq_push),
    .q_op_o       (fq_op),
    .q_value_o    (fq_value),
    .q_full_i     (fq_full)
  );

  deq_cmd_queue #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_push),
    .op_i    (fq_op),
    .value_i (fq_value),
    .full_o  (fq_full),
    .pop_i   (qb_pop),
    .valid_o (qb_valid),
    .op_o    (qb_op),
    .value_o (qb_value)
  );

  deq_back #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (qb_valid),
    .q_op_i        (qb_op),
    .q_value_i     (qb_value),
    .q_pop_o       (qb_pop),
    .out_valid_o   (out_valid_o),
    .out_value_o   (out_value),
    .status_o      (status_o),
    .last_of_run_o (last_of_run_o)
  );

  assign out_value_o = out_value;

endmodule

`default_nettype wire
